// File: hdl/abad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// abad_pkg
// Shared types and constants of the arcade bus address decoder: transaction
// structs, decoded command format, memory map addresses and store sizes.
// ---------------------------------------------------------------------------
package abad_pkg;

    // store geometry
    localparam int MEM_AW      = 19;            // byte address of main memory
    localparam int ROW_AW      = MEM_AW - 1;    // row of one byte bank
    localparam int TX_AW       = 11;
    localparam int BG_AW       = 13;
    localparam int FG_AW       = 12;
    localparam int ROM_BYTES_DEF   = 196608;
    localparam int QUEUE_DEPTH_DEF = 2;

    // opcodes
    localparam logic [2:0] OP_READ8      = 3'd0;
    localparam logic [2:0] OP_READ16     = 3'd1;
    localparam logic [2:0] OP_WRITE8     = 3'd2;
    localparam logic [2:0] OP_WRITE16    = 3'd3;
    localparam logic [2:0] OP_DSP_READ   = 3'd4;
    localparam logic [2:0] OP_DSP_WRITE  = 3'd5;
    localparam logic [2:0] OP_ROM_LOAD   = 3'd6;
    localparam logic [2:0] OP_NOP        = 3'd7;

    // dsp ports
    localparam logic [2:0] PORT_ADDR = 3'd0;
    localparam logic [2:0] PORT_DATA = 3'd1;

    // memory map
    localparam logic [23:0] ADDR_MAIN_END  = 24'h060000;
    localparam logic [23:0] ADDR_ROM_LIMIT = 24'h030000;
    localparam logic [23:0] ADDR_RAM0_LO   = 24'h030000;
    localparam logic [23:0] ADDR_RAM0_HI   = 24'h034000;
    localparam logic [23:0] ADDR_RAM1_LO   = 24'h040000;
    localparam logic [23:0] ADDR_RAM1_HI   = 24'h041000;
    localparam logic [23:0] ADDR_RAM2_LO   = 24'h050000;
    localparam logic [23:0] ADDR_RAM2_HI   = 24'h050e00;
    localparam logic [23:0] ADDR_SHARED_LO = 24'h07a000;
    localparam logic [23:0] ADDR_SHARED_HI = 24'h07b000;
    localparam logic [23:0] ADDR_ACK_BYTE  = 24'h07a001;
    localparam logic [23:0] ADDR_INPUT_LO  = 24'h078000;
    localparam logic [23:0] ADDR_INPUT_HI  = 24'h07800a;
    localparam logic [23:0] ADDR_STATUS    = 24'h078008;
    localparam logic [23:0] ADDR_LATCH     = 24'h07800c;
    localparam logic [23:0] ADDR_TX_OFFSET = 24'h070004;
    localparam logic [23:0] ADDR_BG_OFFSET = 24'h072004;
    localparam logic [23:0] ADDR_FG_OFFSET = 24'h074004;
    localparam logic [23:0] ADDR_TX_PORT   = 24'h07e000;
    localparam logic [23:0] ADDR_BG_PORT   = 24'h07e002;
    localparam logic [23:0] ADDR_FG_PORT   = 24'h07e004;

    // control latch bits
    localparam logic [2:0] LATCH_INT_ENABLE = 3'd2;
    localparam logic [2:0] LATCH_BG_BANK    = 3'd4;
    localparam logic [2:0] LATCH_DSP_RUN    = 3'd6;

    // dsp segments that may be written, top three bits of the segment
    localparam logic [2:0] SEG_SHARED = 3'd3;
    localparam logic [2:0] SEG_RAM1   = 3'd4;
    localparam logic [2:0] SEG_RAM2   = 3'd5;

    localparam logic [15:0] STATUS_VBLANK = 16'hff7f;
    localparam logic [15:0] ALL_ONES_WORD = 16'hffff;
    localparam logic [15:0] ALL_ONES_BYTE = 16'h00ff;
    localparam logic [7:0]  ACK_VALUE     = 8'hff;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [23:0] address;
        logic [15:0] data;
        logic [2:0]  dsp_port;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_clear;
        logic        int_enable;
        logic        dsp_start;
        logic        dsp_complete;
    } out_item_t;

    typedef enum logic [3:0] {
        K_NONE,
        K_CONST,
        K_MEM_RD,
        K_MEM_WR,
        K_STATUS,
        K_VRAM_RD,
        K_VRAM_WR,
        K_OFFSET_WR,
        K_LATCH_WR,
        K_DSP_SET,
        K_DSP_RD,
        K_DSP_WR
    } cmd_kind_t;

    typedef enum logic [1:0] {
        VS_TEXT,
        VS_BG,
        VS_FG
    } vram_sel_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               is_word;
        logic               ack_low;
        vram_sel_t          vsel;
        logic [MEM_AW-1:0]  addr;
        logic [15:0]        data;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_ACCESS
    } back_state_t;

endpackage
`default_nettype wire

// File: hdl/arcade_bus_address_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// arcade_bus_address_decoder
// Bus address decoder for the main cpu and dsp bridge of an arcade board:
// decode part, command queue, execute part with the stores, result queue.
//
//   channel   direction  handshake      payload
//   request   in         push / full    abad_pkg::in_item_t
//   result    out        pop / empty    abad_pkg::out_item_t
//
// In the execute part each transaction passes the idle and access states,
// since the single-port stores are read through a register; one transaction
// is executed at a time. Decode and execute are parted by a small queue, and
// results wait in a queue of their own, so either side may stall independently.
// After reset all stores are swept to zero, with full held.
// ---------------------------------------------------------------------------
module arcade_bus_address_decoder #(
    parameter int ROM_BYTES   = abad_pkg::ROM_BYTES_DEF,
    parameter int QUEUE_DEPTH = abad_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire abad_pkg::in_item_t  request,
    input  wire logic                pop,
    output logic                     empty,
    output abad_pkg::out_item_t      result
);
    abad_pkg::cmd_t      dec_cmd, cmd_head;
    abad_pkg::out_item_t res_item;
    logic cmd_full, cmd_empty, cmd_pop;
    logic res_full, res_push;
    logic clearing;

    // decode
    abad_front #(
        .ROM_BYTES (ROM_BYTES)
    ) u_front (
        .req (request),
        .cmd (dec_cmd)
    );

    assign full = cmd_full || clearing;

    // command queue
    abad_fifo #(
        .T     (abad_pkg::cmd_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !full),
        .din   (dec_cmd),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_head),
        .empty (cmd_empty)
    );

    // execute
    abad_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_item),
        .clearing  (clearing)
    );

    // result queue
    abad_fifo #(
        .T     (abad_pkg::out_item_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_item),
        .full  (res_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

    // a finished transaction always finds room in the result queue
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    // execute part only takes commands that are present
    a_cmd_present: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command taken from an empty queue");

    // no result can exist before the clearing sweep ends
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> empty && cmd_empty)
        else $error("transaction present during clearing sweep");

    // one latch write raises at most one of the two pulses
    a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(result.irq_clear && result.dsp_start))
        else $error("irq_clear and dsp_start raised together");

endmodule
`default_nettype wire

// File: hdl/abad_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// abad_fifo
// Small synchronous queue of transactions, used between the decode and
// execute parts and in front of the result port.
// ---------------------------------------------------------------------------
module abad_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = abad_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire T     din,
    output logic      full,
    input  wire logic pop,
    output T          dout,
    output logic      empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    T                mem_reg [DEPTH];
    logic [AW-1:0]   wptr_reg;
    logic [AW-1:0]   rptr_reg;
    logic [AW:0]     count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/abad_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// abad_front
// Classifies one bus transaction against the memory map and turns it into
// a decoded command for the execute part.
// ---------------------------------------------------------------------------
module abad_front #(
    parameter int ROM_BYTES = abad_pkg::ROM_BYTES_DEF
) (
    input  wire abad_pkg::in_item_t req,
    output abad_pkg::cmd_t          cmd
);
    logic [23:0] a;
    logic        writable;

    assign a = req.address;

    // ram regions open to cpu writes
    assign writable =
        (a >= abad_pkg::ADDR_RAM0_LO && a < abad_pkg::ADDR_RAM0_HI) ||
        (a >= abad_pkg::ADDR_RAM1_LO && a < abad_pkg::ADDR_RAM1_HI) ||
        (a >= abad_pkg::ADDR_RAM2_LO && a < abad_pkg::ADDR_RAM2_HI) ||
        (a >= abad_pkg::ADDR_SHARED_LO && a < abad_pkg::ADDR_SHARED_HI);

    // address decode
    always_comb
    begin
        cmd         = '0;
        cmd.kind    = abad_pkg::K_NONE;
        cmd.vsel    = abad_pkg::VS_TEXT;
        cmd.addr    = a[abad_pkg::MEM_AW-1:0];
        cmd.data    = req.data;
        cmd.is_word = 1'b1;
        case (req.opcode)
            abad_pkg::OP_READ8:
            begin
                cmd.is_word = 1'b0;
                if (a < abad_pkg::ADDR_MAIN_END)
                begin
                    cmd.kind = abad_pkg::K_MEM_RD;
                end
                else if (a == abad_pkg::ADDR_ACK_BYTE)
                begin
                    cmd.kind = abad_pkg::K_CONST;
                end
                else if (a >= abad_pkg::ADDR_SHARED_LO && a < abad_pkg::ADDR_SHARED_HI)
                begin
                    cmd.kind = abad_pkg::K_MEM_RD;
                end
                else if (a[23:1] == abad_pkg::ADDR_STATUS[23:1])
                begin
                    cmd.kind = abad_pkg::K_STATUS;
                end
                else
                begin
                    cmd.kind = abad_pkg::K_CONST;
                end
            end
            abad_pkg::OP_READ16:
            begin
                if (a < abad_pkg::ADDR_MAIN_END)
                begin
                    cmd.kind = abad_pkg::K_MEM_RD;
                end
                else if (a == abad_pkg::ADDR_STATUS)
                begin
                    cmd.kind = abad_pkg::K_STATUS;
                end
                else if (a == abad_pkg::ADDR_TX_PORT)
                begin
                    cmd.kind = abad_pkg::K_VRAM_RD;
                    cmd.vsel = abad_pkg::VS_TEXT;
                end
                else if (a == abad_pkg::ADDR_BG_PORT)
                begin
                    cmd.kind = abad_pkg::K_VRAM_RD;
                    cmd.vsel = abad_pkg::VS_BG;
                end
                else if (a == abad_pkg::ADDR_FG_PORT)
                begin
                    cmd.kind = abad_pkg::K_VRAM_RD;
                    cmd.vsel = abad_pkg::VS_FG;
                end
                else if (a >= abad_pkg::ADDR_INPUT_LO && a < abad_pkg::ADDR_INPUT_HI)
                begin
                    cmd.kind = abad_pkg::K_CONST;
                end
                else if (a >= abad_pkg::ADDR_SHARED_LO && a < abad_pkg::ADDR_SHARED_HI)
                begin
                    cmd.kind    = abad_pkg::K_MEM_RD;
                    cmd.ack_low = (a == abad_pkg::ADDR_SHARED_LO);
                end
                else
                begin
                    cmd.kind = abad_pkg::K_CONST;
                end
            end
            abad_pkg::OP_WRITE8:
            begin
                cmd.is_word = 1'b0;
                if (writable)
                begin
                    cmd.kind = abad_pkg::K_MEM_WR;
                end
            end
            abad_pkg::OP_WRITE16:
            begin
                if (writable)
                begin
                    cmd.kind = abad_pkg::K_MEM_WR;
                end
                else
                begin
                    case (a)
                        abad_pkg::ADDR_TX_OFFSET:
                        begin
                            cmd.kind = abad_pkg::K_OFFSET_WR;
                            cmd.vsel = abad_pkg::VS_TEXT;
                        end
                        abad_pkg::ADDR_BG_OFFSET:
                        begin
                            cmd.kind = abad_pkg::K_OFFSET_WR;
                            cmd.vsel = abad_pkg::VS_BG;
                        end
                        abad_pkg::ADDR_FG_OFFSET:
                        begin
                            cmd.kind = abad_pkg::K_OFFSET_WR;
                            cmd.vsel = abad_pkg::VS_FG;
                        end
                        abad_pkg::ADDR_TX_PORT:
                        begin
                            cmd.kind = abad_pkg::K_VRAM_WR;
                            cmd.vsel = abad_pkg::VS_TEXT;
                        end
                        abad_pkg::ADDR_BG_PORT:
                        begin
                            cmd.kind = abad_pkg::K_VRAM_WR;
                            cmd.vsel = abad_pkg::VS_BG;
                        end
                        abad_pkg::ADDR_FG_PORT:
                        begin
                            cmd.kind = abad_pkg::K_VRAM_WR;
                            cmd.vsel = abad_pkg::VS_FG;
                        end
                        abad_pkg::ADDR_LATCH:
                        begin
                            cmd.kind = abad_pkg::K_LATCH_WR;
                        end
                        default:
                        begin
                            cmd.kind = abad_pkg::K_NONE;
                        end
                    endcase
                end
            end
            abad_pkg::OP_DSP_READ:
            begin
                if (req.dsp_port == abad_pkg::PORT_DATA)
                begin
                    cmd.kind = abad_pkg::K_DSP_RD;
                end
            end
            abad_pkg::OP_DSP_WRITE:
            begin
                if (req.dsp_port == abad_pkg::PORT_ADDR)
                begin
                    cmd.kind = abad_pkg::K_DSP_SET;
                end
                else if (req.dsp_port == abad_pkg::PORT_DATA)
                begin
                    cmd.kind = abad_pkg::K_DSP_WR;
                end
            end
            abad_pkg::OP_ROM_LOAD:
            begin
                cmd.is_word = 1'b0;
                if (a < 24'(ROM_BYTES) && a < abad_pkg::ADDR_ROM_LIMIT)
                begin
                    cmd.kind = abad_pkg::K_MEM_WR;
                end
            end
            default:
            begin
                cmd.kind = abad_pkg::K_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/abad_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// abad_back
// Executes decoded commands: owns main memory (two byte banks), the three
// vram stores, offset, latch, poll and dsp registers, and forms results.
// Clears all stores after reset, one row per cycle.
// ---------------------------------------------------------------------------
module abad_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire abad_pkg::cmd_t     cmd,
    input  wire logic               cmd_empty,
    output logic                    cmd_pop,
    input  wire logic               res_full,
    output logic                    res_push,
    output abad_pkg::out_item_t     res,
    output logic                    clearing
);
    localparam int ROWS = 2 ** abad_pkg::ROW_AW;

    abad_pkg::back_state_t state_reg, state_next;

    // stores
    logic [7:0]  even_mem [ROWS];
    logic [7:0]  odd_mem  [ROWS];
    logic [15:0] tx_mem   [2 ** abad_pkg::TX_AW];
    logic [15:0] bg_mem   [2 ** abad_pkg::BG_AW];
    logic [15:0] fg_mem   [2 ** abad_pkg::FG_AW];
    logic [7:0]  even_q_reg, odd_q_reg;
    logic [15:0] tx_q_reg, bg_q_reg, fg_q_reg;

    // clearing sweep
    logic                       clr_busy_reg;
    logic [abad_pkg::ROW_AW-1:0] clr_cnt_reg;

    // architectural registers
    logic        int_en_reg;
    logic        bg_bank_reg;
    logic [abad_pkg::TX_AW-1:0] tx_off_reg;
    logic [11:0] bg_off_reg;
    logic [abad_pkg::FG_AW-1:0] fg_off_reg;
    logic [9:0]  poll_reg;
    logic [2:0]  dseg_reg;
    logic [12:0] dwa_reg;

    // held transaction
    abad_pkg::cmd_t cur_reg;
    logic [15:0] direct_reg;
    logic        irq_reg, run_reg, done_reg;
    logic        a0_reg;

    logic        start;
    logic        is_dsp;
    logic        seg_ok;
    logic [abad_pkg::MEM_AW-1:0] bridge_addr, acc_addr, addr_p1;
    logic [abad_pkg::ROW_AW-1:0] even_row, odd_row;
    logic        mem_we, we_even, we_odd;
    logic [7:0]  hi_byte_w, wd_even, wd_odd;
    logic        tx_we, bg_we, fg_we;
    logic [abad_pkg::TX_AW-1:0] tx_idx;
    logic [abad_pkg::BG_AW-1:0] bg_idx;
    logic [abad_pkg::FG_AW-1:0] fg_idx;
    logic [15:0] tx_wd;
    logic [9:0]  poll_inc;
    logic [15:0] status_word;
    logic [15:0] direct_next;
    logic [2:0]  latch_idx;
    logic [7:0]  hi_q, lo_q;
    logic [15:0] mem_word, vram_word;

    assign clearing = clr_busy_reg;
    assign start    = (state_reg == abad_pkg::BK_IDLE) && !cmd_empty && !res_full
                      && !clr_busy_reg;

    // dsp address and write permission
    assign is_dsp      = (cmd.kind == abad_pkg::K_DSP_RD) || (cmd.kind == abad_pkg::K_DSP_WR);
    assign bridge_addr = {dseg_reg, 16'h0000} + {5'b0, dwa_reg, 1'b0};
    assign seg_ok      = (dseg_reg == abad_pkg::SEG_SHARED) || (dseg_reg == abad_pkg::SEG_RAM1)
                         || (dseg_reg == abad_pkg::SEG_RAM2);

    // byte bank addressing: high byte at the address, low byte at the next one
    assign acc_addr = is_dsp ? bridge_addr : cmd.addr;
    assign addr_p1  = acc_addr + 1'b1;
    assign odd_row  = acc_addr[abad_pkg::MEM_AW-1:1];
    assign even_row = acc_addr[0] ? addr_p1[abad_pkg::MEM_AW-1:1]
                                  : acc_addr[abad_pkg::MEM_AW-1:1];

    assign mem_we    = start && ((cmd.kind == abad_pkg::K_MEM_WR) ||
                                 ((cmd.kind == abad_pkg::K_DSP_WR) && seg_ok));
    assign we_even   = mem_we && (!acc_addr[0] || cmd.is_word);
    assign we_odd    = mem_we && (acc_addr[0] || cmd.is_word);
    assign hi_byte_w = cmd.is_word ? cmd.data[15:8] : cmd.data[7:0];
    assign wd_even   = acc_addr[0] ? cmd.data[7:0] : hi_byte_w;
    assign wd_odd    = acc_addr[0] ? hi_byte_w : cmd.data[7:0];

    // vram ports
    assign tx_idx = tx_off_reg;
    assign bg_idx = {bg_bank_reg, bg_off_reg};
    assign fg_idx = fg_off_reg;
    assign tx_wd  = cmd.data;
    assign tx_we  = start && (cmd.kind == abad_pkg::K_VRAM_WR) && (cmd.vsel == abad_pkg::VS_TEXT);
    assign bg_we  = start && (cmd.kind == abad_pkg::K_VRAM_WR) && (cmd.vsel == abad_pkg::VS_BG);
    assign fg_we  = start && (cmd.kind == abad_pkg::K_VRAM_WR) && (cmd.vsel == abad_pkg::VS_FG);

    // main memory banks, cleared by the sweep
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            even_mem[clr_cnt_reg] <= 8'h00;
            odd_mem[clr_cnt_reg]  <= 8'h00;
        end
        else
        begin
            if (we_even)
            begin
                even_mem[even_row] <= wd_even;
            end
            if (we_odd)
            begin
                odd_mem[odd_row] <= wd_odd;
            end
        end
        even_q_reg <= even_mem[even_row];
        odd_q_reg  <= odd_mem[odd_row];
    end

    // vram stores, cleared by the same sweep
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            tx_mem[clr_cnt_reg[abad_pkg::TX_AW-1:0]] <= 16'h0000;
            bg_mem[clr_cnt_reg[abad_pkg::BG_AW-1:0]] <= 16'h0000;
            fg_mem[clr_cnt_reg[abad_pkg::FG_AW-1:0]] <= 16'h0000;
        end
        else
        begin
            if (tx_we)
            begin
                tx_mem[tx_idx] <= tx_wd;
            end
            if (bg_we)
            begin
                bg_mem[bg_idx] <= tx_wd;
            end
            if (fg_we)
            begin
                fg_mem[fg_idx] <= tx_wd;
            end
        end
        tx_q_reg <= tx_mem[tx_idx];
        bg_q_reg <= bg_mem[bg_idx];
        fg_q_reg <= fg_mem[fg_idx];
    end

    // results that need no store read
    assign poll_inc    = poll_reg + 1'b1;
    assign status_word = poll_inc[9] ? abad_pkg::STATUS_VBLANK : abad_pkg::ALL_ONES_WORD;
    assign latch_idx   = cmd.data[3:1];
    always_comb
    begin
        case (cmd.kind)
            abad_pkg::K_CONST:
            begin
                direct_next = cmd.is_word ? abad_pkg::ALL_ONES_WORD : abad_pkg::ALL_ONES_BYTE;
            end
            abad_pkg::K_STATUS:
            begin
                if (cmd.is_word)
                begin
                    direct_next = status_word;
                end
                else
                begin
                    direct_next = {8'h00, cmd.addr[0] ? status_word[7:0] : status_word[15:8]};
                end
            end
            default:
            begin
                direct_next = 16'h0000;
            end
        endcase
    end

    // held transaction and pulses
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg    <= cmd;
            direct_reg <= direct_next;
            a0_reg     <= acc_addr[0];
            irq_reg    <= (cmd.kind == abad_pkg::K_LATCH_WR) &&
                          (latch_idx == abad_pkg::LATCH_INT_ENABLE) && !cmd.data[0];
            run_reg    <= (cmd.kind == abad_pkg::K_LATCH_WR) &&
                          (latch_idx == abad_pkg::LATCH_DSP_RUN) && cmd.data[0];
            done_reg   <= (cmd.kind == abad_pkg::K_DSP_WR) &&
                          (dseg_reg == abad_pkg::SEG_SHARED) &&
                          (dwa_reg[12:1] == '0) && (cmd.data == 16'h0000);
        end
    end

    // state registers, sweep and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= abad_pkg::BK_IDLE;
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            int_en_reg   <= 1'b0;
            bg_bank_reg  <= 1'b0;
            tx_off_reg   <= '0;
            bg_off_reg   <= '0;
            fg_off_reg   <= '0;
            poll_reg     <= '0;
            dseg_reg     <= '0;
            dwa_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (start)
            begin
                case (cmd.kind)
                    abad_pkg::K_STATUS:
                    begin
                        poll_reg <= poll_inc;
                    end
                    abad_pkg::K_OFFSET_WR:
                    begin
                        case (cmd.vsel)
                            abad_pkg::VS_TEXT: tx_off_reg <= cmd.data[abad_pkg::TX_AW-1:0];
                            abad_pkg::VS_BG:   bg_off_reg <= cmd.data[11:0];
                            abad_pkg::VS_FG:   fg_off_reg <= cmd.data[abad_pkg::FG_AW-1:0];
                            default:           tx_off_reg <= tx_off_reg;
                        endcase
                    end
                    abad_pkg::K_LATCH_WR:
                    begin
                        if (latch_idx == abad_pkg::LATCH_INT_ENABLE)
                        begin
                            int_en_reg <= cmd.data[0];
                        end
                        if (latch_idx == abad_pkg::LATCH_BG_BANK)
                        begin
                            bg_bank_reg <= cmd.data[0];
                        end
                    end
                    abad_pkg::K_DSP_SET:
                    begin
                        dseg_reg <= cmd.data[15:13];
                        dwa_reg  <= cmd.data[12:0];
                    end
                    default:
                    begin
                        poll_reg <= poll_reg;
                    end
                endcase
            end
        end
    end

    // next state
    always_comb
    begin
        case (state_reg)
            abad_pkg::BK_IDLE:   state_next = start ? abad_pkg::BK_ACCESS : abad_pkg::BK_IDLE;
            abad_pkg::BK_ACCESS: state_next = abad_pkg::BK_IDLE;
            default:             state_next = abad_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        case (state_reg)
            abad_pkg::BK_IDLE:
            begin
                cmd_pop  = start;
                res_push = 1'b0;
            end
            abad_pkg::BK_ACCESS:
            begin
                cmd_pop  = 1'b0;
                res_push = 1'b1;
            end
            default:
            begin
                cmd_pop  = 1'b0;
                res_push = 1'b0;
            end
        endcase
    end

    // result assembly from registered store data
    assign hi_q     = a0_reg ? odd_q_reg : even_q_reg;
    assign lo_q     = a0_reg ? even_q_reg : odd_q_reg;
    assign mem_word = cur_reg.is_word ? {hi_q, cur_reg.ack_low ? abad_pkg::ACK_VALUE : lo_q}
                                      : {8'h00, hi_q};
    always_comb
    begin
        case (cur_reg.vsel)
            abad_pkg::VS_TEXT: vram_word = tx_q_reg;
            abad_pkg::VS_BG:   vram_word = bg_q_reg;
            abad_pkg::VS_FG:   vram_word = fg_q_reg;
            default:           vram_word = 16'h0000;
        endcase
    end

    always_comb
    begin
        res              = '0;
        res.int_enable   = int_en_reg;
        res.irq_clear    = irq_reg;
        res.dsp_start    = run_reg;
        res.dsp_complete = done_reg;
        case (cur_reg.kind)
            abad_pkg::K_MEM_RD,
            abad_pkg::K_DSP_RD:  res.read_data = mem_word;
            abad_pkg::K_VRAM_RD: res.read_data = vram_word;
            abad_pkg::K_CONST,
            abad_pkg::K_STATUS:  res.read_data = direct_reg;
            default:             res.read_data = 16'h0000;
        endcase
    end

endmodule
`default_nettype wire
